[hw/rtl/gkg_pkg.sv]
// Package for the 3D Gaussian kernel generator.
// Holds shared widths, constants, controller states, commands and status.
// No dependencies.
`default_nettype none

package gkg_pkg;

    // default parameter values
    localparam int MAX_EXTENT_DEF      = 16;
    localparam int VALUE_FRAC_BITS_DEF = 16;

    // fixed field widths
    localparam int SIZE_W   = 5;
    localparam int COEF_W   = 20;
    localparam int POS_W    = 4;
    localparam int OUTC_W   = 25;
    localparam int TOTAL_W  = 29;
    localparam int STAT_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_Z = 3'd5;

    // reset values of the registers
    localparam logic [SIZE_W-1:0] SIZE_RST = 5'd5;
    localparam logic [COEF_W-1:0] COEF_RST = 20'd32768;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd2;

    // fixed point of the exponential
    localparam int Q_W       = 31;             // Q1.30 value width
    localparam int PROD_W    = 62;
    localparam int ARG_FRAC  = 18;
    localparam int ARG_INT_W = 4;              // a < 16 once not saturated
    localparam int SER_TERMS = 30;
    localparam int K_W       = 5;
    localparam int SUM_W     = 33;
    localparam logic [Q_W-1:0]    Q30_ONE  = 31'h4000_0000;
    localparam logic [PROD_W-1:0] Q30_HALF = 62'h2000_0000;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_BLD_INIT,
        S_SER_INIT,
        S_SER_MUL,
        S_SER_DIV_LD,
        S_SER_DIV_WAIT,
        S_SER_END,
        S_ARG_MX,
        S_ARG_MY,
        S_ARG_MZ,
        S_ARG_FIN,
        S_ARG_CHK,
        S_POW_MUL,
        S_POW_UPD,
        S_VOX_STORE,
        S_RD_ISSUE,
        S_RD_LOAD,
        S_RD_WAIT,
        S_RESULT
    } state_t;

    // datapath commands
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_ITEM_LOAD,
        CMD_BLD_INIT,
        CMD_SER_INIT_ONE,
        CMD_SER_INIT_ARG,
        CMD_SER_MUL,
        CMD_DIV_LD_SER,
        CMD_SER_UPD,
        CMD_EINV_SAVE,
        CMD_R_FROM_SUM,
        CMD_ARG_MX,
        CMD_ARG_MY,
        CMD_ARG_MZ,
        CMD_ARG_FIN,
        CMD_R_ZERO,
        CMD_POW_MUL,
        CMD_POW_UPD,
        CMD_VOX_STORE,
        CMD_RD_ISSUE,
        CMD_RD_LOAD,
        CMD_OUT_LOAD
    } cmd_t;

    // datapath status back to the controller
    typedef struct packed {
        logic item_func;
        logic built;
        logic in_range;
        logic div_done;
        logic k_last;
        logic n_zero;
        logic n_one;
        logic arg_big;
        logic last_voxel;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/gkg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gkg_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/gkg_ctrl.sv]
// Controller state machine of the 3D Gaussian kernel generator.
// Sequences builds and reads over gkg_dp; uses gkg_pkg.
`default_nettype none

module gkg_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire gkg_pkg::dp_status_t st,
    output gkg_pkg::cmd_t           cmd
);

    gkg_pkg::state_t state_reg, state_next;
    logic            einv_reg, einv_next;   // series is forming exp(-1)

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gkg_pkg::S_IDLE;
            einv_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            einv_reg  <= einv_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        einv_next  = einv_reg;
        cmd        = gkg_pkg::CMD_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            gkg_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd        = gkg_pkg::CMD_ITEM_LOAD;
                    state_next = gkg_pkg::S_DISPATCH;
                end
            end
            gkg_pkg::S_DISPATCH: begin
                if (!st.item_func) begin
                    state_next = gkg_pkg::S_BLD_INIT;
                end else if (!st.built || !st.in_range) begin
                    state_next = gkg_pkg::S_RESULT;
                end else begin
                    state_next = gkg_pkg::S_RD_ISSUE;
                end
            end
            gkg_pkg::S_BLD_INIT: begin
                cmd        = gkg_pkg::CMD_BLD_INIT;
                einv_next  = 1'b1;
                state_next = gkg_pkg::S_SER_INIT;
            end
            gkg_pkg::S_SER_INIT: begin
                cmd        = einv_reg ? gkg_pkg::CMD_SER_INIT_ONE : gkg_pkg::CMD_SER_INIT_ARG;
                state_next = gkg_pkg::S_SER_MUL;
            end
            gkg_pkg::S_SER_MUL: begin
                cmd        = gkg_pkg::CMD_SER_MUL;
                state_next = gkg_pkg::S_SER_DIV_LD;
            end
            gkg_pkg::S_SER_DIV_LD: begin
                cmd        = gkg_pkg::CMD_DIV_LD_SER;
                state_next = gkg_pkg::S_SER_DIV_WAIT;
            end
            gkg_pkg::S_SER_DIV_WAIT: begin
                if (st.div_done) begin
                    cmd        = gkg_pkg::CMD_SER_UPD;
                    state_next = st.k_last ? gkg_pkg::S_SER_END : gkg_pkg::S_SER_MUL;
                end
            end
            gkg_pkg::S_SER_END: begin
                if (einv_reg) begin
                    cmd        = gkg_pkg::CMD_EINV_SAVE;
                    einv_next  = 1'b0;
                    state_next = gkg_pkg::S_ARG_MX;
                end else begin
                    cmd        = gkg_pkg::CMD_R_FROM_SUM;
                    state_next = st.n_zero ? gkg_pkg::S_VOX_STORE : gkg_pkg::S_POW_MUL;
                end
            end
            gkg_pkg::S_ARG_MX: begin
                cmd        = gkg_pkg::CMD_ARG_MX;
                state_next = gkg_pkg::S_ARG_MY;
            end
            gkg_pkg::S_ARG_MY: begin
                cmd        = gkg_pkg::CMD_ARG_MY;
                state_next = gkg_pkg::S_ARG_MZ;
            end
            gkg_pkg::S_ARG_MZ: begin
                cmd        = gkg_pkg::CMD_ARG_MZ;
                state_next = gkg_pkg::S_ARG_FIN;
            end
            gkg_pkg::S_ARG_FIN: begin
                cmd        = gkg_pkg::CMD_ARG_FIN;
                state_next = gkg_pkg::S_ARG_CHK;
            end
            gkg_pkg::S_ARG_CHK: begin
                if (st.arg_big) begin
                    cmd        = gkg_pkg::CMD_R_ZERO;
                    state_next = gkg_pkg::S_VOX_STORE;
                end else begin
                    state_next = gkg_pkg::S_SER_INIT;
                end
            end
            gkg_pkg::S_POW_MUL: begin
                cmd        = gkg_pkg::CMD_POW_MUL;
                state_next = gkg_pkg::S_POW_UPD;
            end
            gkg_pkg::S_POW_UPD: begin
                cmd        = gkg_pkg::CMD_POW_UPD;
                state_next = st.n_one ? gkg_pkg::S_VOX_STORE : gkg_pkg::S_POW_MUL;
            end
            gkg_pkg::S_VOX_STORE: begin
                cmd        = gkg_pkg::CMD_VOX_STORE;
                state_next = st.last_voxel ? gkg_pkg::S_RESULT : gkg_pkg::S_ARG_MX;
            end
            gkg_pkg::S_RD_ISSUE: begin
                cmd        = gkg_pkg::CMD_RD_ISSUE;
                state_next = gkg_pkg::S_RD_LOAD;
            end
            gkg_pkg::S_RD_LOAD: begin
                cmd        = gkg_pkg::CMD_RD_LOAD;
                state_next = gkg_pkg::S_RD_WAIT;
            end
            gkg_pkg::S_RD_WAIT: begin
                if (st.div_done) begin
                    state_next = gkg_pkg::S_RESULT;
                end
            end
            gkg_pkg::S_RESULT: begin
                if (st.out_free) begin
                    cmd        = gkg_pkg::CMD_OUT_LOAD;
                    state_next = gkg_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = gkg_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/gkg_dp.sv]
// Datapath of the 3D Gaussian kernel generator: config registers, shared
// multiplier, restoring divider, series registers, kernel store, result register.
// Uses gkg_pkg and gkg_ram.
`default_nettype none

module gkg_dp #(
    parameter int MAX_EXTENT      = gkg_pkg::MAX_EXTENT_DEF,
    parameter int VALUE_FRAC_BITS = gkg_pkg::VALUE_FRAC_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [gkg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gkg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_func,
    input  wire logic [gkg_pkg::POS_W-1:0]       s_x_pos,
    input  wire logic [gkg_pkg::POS_W-1:0]       s_y_pos,
    input  wire logic [gkg_pkg::POS_W-1:0]       s_z_pos,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [gkg_pkg::OUTC_W-1:0]           m_coefficient,
    output logic [gkg_pkg::TOTAL_W-1:0]          m_total,
    output logic [gkg_pkg::STAT_W-1:0]           m_status,
    input  wire gkg_pkg::cmd_t                   cmd,
    output gkg_pkg::dp_status_t                  st
);

    localparam int IDX_W  = $clog2(MAX_EXTENT);
    localparam int EXT_W  = $clog2(MAX_EXTENT + 1);
    localparam int SQ_W   = 2 * IDX_W;
    localparam int DEPTH  = MAX_EXTENT * MAX_EXTENT * MAX_EXTENT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int VAL_W  = VALUE_FRAC_BITS + 1;
    localparam int DVD_W  = (VALUE_FRAC_BITS + 25 > gkg_pkg::Q_W) ?
                            VALUE_FRAC_BITS + 25 : gkg_pkg::Q_W;
    localparam int CNT_W  = $clog2(DVD_W + 1);
    localparam int ARG_W  = gkg_pkg::COEF_W + SQ_W + 2;
    localparam int RSH    = 30 - VALUE_FRAC_BITS;
    localparam logic [31:0] V_RND = 32'(1) << (29 - VALUE_FRAC_BITS);

    // squared doubled offset from the centre
    function automatic logic [SQ_W-1:0] sq_off(input logic [IDX_W-1:0] i,
                                                input logic [EXT_W-1:0] s);
        int d;
        d = 2 * int'(i) - (int'(s) - 1);
        if (d < 0) begin
            d = -d;
        end
        return SQ_W'(d * d);
    endfunction

    function automatic logic [EXT_W-1:0] clamp_ext(input logic [gkg_pkg::SIZE_W-1:0] s);
        if (s == '0) begin
            return EXT_W'(1);
        end else if (int'(s) > MAX_EXTENT) begin
            return EXT_W'(MAX_EXTENT);
        end
        return EXT_W'(s);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input int z, input int y, input int x);
        return ADDR_W'((z * MAX_EXTENT + y) * MAX_EXTENT + x);
    endfunction

    // configuration registers
    logic [gkg_pkg::SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [gkg_pkg::COEF_W-1:0] coef_x_reg, coef_y_reg, coef_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= gkg_pkg::SIZE_RST;
            size_y_reg <= gkg_pkg::SIZE_RST;
            size_z_reg <= gkg_pkg::SIZE_RST;
            coef_x_reg <= gkg_pkg::COEF_RST;
            coef_y_reg <= gkg_pkg::COEF_RST;
            coef_z_reg <= gkg_pkg::COEF_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gkg_pkg::CFG_SIZE_X: size_x_reg <= cfg_wdata[gkg_pkg::SIZE_W-1:0];
                gkg_pkg::CFG_SIZE_Y: size_y_reg <= cfg_wdata[gkg_pkg::SIZE_W-1:0];
                gkg_pkg::CFG_SIZE_Z: size_z_reg <= cfg_wdata[gkg_pkg::SIZE_W-1:0];
                gkg_pkg::CFG_COEF_X: coef_x_reg <= cfg_wdata;
                gkg_pkg::CFG_COEF_Y: coef_y_reg <= cfg_wdata;
                gkg_pkg::CFG_COEF_Z: coef_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // request, built extents, total and built flag
    logic                      func_reg;
    logic [gkg_pkg::POS_W-1:0] xp_reg, yp_reg, zp_reg;
    logic [EXT_W-1:0]          bx_reg, by_reg, bz_reg;
    logic [gkg_pkg::TOTAL_W-1:0] total_reg;
    logic                      built_reg;
    logic [IDX_W-1:0]          vx_reg, vy_reg, vz_reg;
    logic                      last_x, last_y, last_z, last_voxel;

    // series, power and argument registers
    logic [gkg_pkg::Q_W-1:0]    term_reg, f_reg, einv_reg, r_reg;
    logic signed [gkg_pkg::SUM_W-1:0] sum_reg;
    logic [gkg_pkg::K_W-1:0]    k_reg;
    logic [gkg_pkg::ARG_INT_W-1:0] n_reg;
    logic [ARG_W-1:0]           arg_reg;
    logic [gkg_pkg::PROD_W-1:0] prod_reg;
    logic [VAL_W-1:0]           v_reg;

    // divider
    logic [DVD_W-1:0]            dvd_reg;
    logic [gkg_pkg::TOTAL_W-1:0] rem_reg, dsr_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [gkg_pkg::TOTAL_W:0]   rem_sh;
    logic                        div_ge;

    // output register
    logic                        m_valid_reg;
    logic [gkg_pkg::OUTC_W-1:0]  coef_out_reg;
    logic [gkg_pkg::TOTAL_W-1:0] total_out_reg;
    logic [gkg_pkg::STAT_W-1:0]  status_out_reg;

    // shared multiplier operands
    logic [gkg_pkg::Q_W-1:0]     mul_a, mul_b;
    logic [gkg_pkg::PROD_W-1:0]  prod_rnd;
    logic [gkg_pkg::Q_W-1:0]     round_q30;
    logic [gkg_pkg::Q_W-1:0]     sum_clamped;
    logic [31:0]                 r_rnd;
    logic [VAL_W-1:0]            v_new;
    logic [gkg_pkg::TOTAL_W:0]   tot_sum;
    logic                        in_range;
    logic                        rd_ok;
    logic [VAL_W-1:0]            ram_rdata;
    logic                        ram_we, ram_re;
    logic [ADDR_W-1:0]           waddr, raddr;

    always_comb begin
        mul_a = term_reg;
        mul_b = f_reg;
        case (cmd)
            gkg_pkg::CMD_ARG_MX: begin
                mul_a = gkg_pkg::Q_W'(coef_x_reg);
                mul_b = gkg_pkg::Q_W'(sq_off(vx_reg, bx_reg));
            end
            gkg_pkg::CMD_ARG_MY: begin
                mul_a = gkg_pkg::Q_W'(coef_y_reg);
                mul_b = gkg_pkg::Q_W'(sq_off(vy_reg, by_reg));
            end
            gkg_pkg::CMD_ARG_MZ: begin
                mul_a = gkg_pkg::Q_W'(coef_z_reg);
                mul_b = gkg_pkg::Q_W'(sq_off(vz_reg, bz_reg));
            end
            gkg_pkg::CMD_POW_MUL: begin
                mul_a = r_reg;
                mul_b = einv_reg;
            end
            default: ;
        endcase
    end

    // Q1.30 round half up of the registered product
    assign prod_rnd    = prod_reg + gkg_pkg::Q30_HALF;
    assign round_q30   = prod_rnd[60:30];
    assign sum_clamped = sum_reg[gkg_pkg::SUM_W-1] ? '0 : sum_reg[gkg_pkg::Q_W-1:0];

    // stored value and saturating total
    assign r_rnd   = 32'(r_reg) + V_RND;
    assign v_new   = r_rnd[RSH +: VAL_W];
    assign tot_sum = (gkg_pkg::TOTAL_W + 1)'(total_reg) + (gkg_pkg::TOTAL_W + 1)'(v_new);

    // divider step
    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign div_ge = rem_sh >= {1'b0, dsr_reg};

    assign last_x     = int'(vx_reg) == int'(bx_reg) - 1;
    assign last_y     = int'(vy_reg) == int'(by_reg) - 1;
    assign last_z     = int'(vz_reg) == int'(bz_reg) - 1;
    assign last_voxel = last_x && last_y && last_z;
    assign in_range   = (int'(xp_reg) < int'(bx_reg)) && (int'(yp_reg) < int'(by_reg)) &&
                        (int'(zp_reg) < int'(bz_reg));
    assign rd_ok      = func_reg && built_reg && in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bx_reg    <= EXT_W'(1);
            by_reg    <= EXT_W'(1);
            bz_reg    <= EXT_W'(1);
            total_reg <= '0;
            built_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            // divider runs by itself once loaded
            if (cnt_reg != '0) begin
                rem_reg <= div_ge ? gkg_pkg::TOTAL_W'(rem_sh - {1'b0, dsr_reg})
                                  : rem_sh[gkg_pkg::TOTAL_W-1:0];
                dvd_reg <= {dvd_reg[DVD_W-2:0], div_ge};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            case (cmd)
                gkg_pkg::CMD_ITEM_LOAD: begin
                    func_reg <= s_func;
                    xp_reg   <= s_x_pos;
                    yp_reg   <= s_y_pos;
                    zp_reg   <= s_z_pos;
                end
                gkg_pkg::CMD_BLD_INIT: begin
                    bx_reg    <= clamp_ext(size_x_reg);
                    by_reg    <= clamp_ext(size_y_reg);
                    bz_reg    <= clamp_ext(size_z_reg);
                    total_reg <= '0;
                    vx_reg    <= '0;
                    vy_reg    <= '0;
                    vz_reg    <= '0;
                end
                gkg_pkg::CMD_SER_INIT_ONE, gkg_pkg::CMD_SER_INIT_ARG: begin
                    term_reg <= gkg_pkg::Q30_ONE;
                    sum_reg  <= gkg_pkg::SUM_W'(gkg_pkg::Q30_ONE);
                    k_reg    <= gkg_pkg::K_W'(1);
                    if (cmd == gkg_pkg::CMD_SER_INIT_ONE) begin
                        f_reg <= gkg_pkg::Q30_ONE;
                    end else begin
                        f_reg <= {1'b0, arg_reg[gkg_pkg::ARG_FRAC-1:0], 12'b0};
                        n_reg <= arg_reg[gkg_pkg::ARG_FRAC +: gkg_pkg::ARG_INT_W];
                    end
                end
                gkg_pkg::CMD_SER_MUL, gkg_pkg::CMD_POW_MUL: begin
                    prod_reg <= gkg_pkg::PROD_W'(mul_a * mul_b);
                end
                gkg_pkg::CMD_DIV_LD_SER: begin
                    dvd_reg <= DVD_W'(round_q30);
                    dsr_reg <= gkg_pkg::TOTAL_W'(k_reg);
                    rem_reg <= '0;
                    cnt_reg <= CNT_W'(DVD_W);
                end
                gkg_pkg::CMD_SER_UPD: begin
                    term_reg <= dvd_reg[gkg_pkg::Q_W-1:0];
                    if (k_reg[0]) begin
                        sum_reg <= sum_reg - gkg_pkg::SUM_W'(dvd_reg[gkg_pkg::Q_W-1:0]);
                    end else begin
                        sum_reg <= sum_reg + gkg_pkg::SUM_W'(dvd_reg[gkg_pkg::Q_W-1:0]);
                    end
                    k_reg <= k_reg + gkg_pkg::K_W'(1);
                end
                gkg_pkg::CMD_EINV_SAVE:  einv_reg <= sum_clamped;
                gkg_pkg::CMD_R_FROM_SUM: r_reg    <= sum_clamped;
                gkg_pkg::CMD_R_ZERO:     r_reg    <= '0;
                gkg_pkg::CMD_ARG_MX: begin
                    arg_reg  <= '0;
                    prod_reg <= gkg_pkg::PROD_W'(mul_a * mul_b);
                end
                gkg_pkg::CMD_ARG_MY, gkg_pkg::CMD_ARG_MZ: begin
                    arg_reg  <= arg_reg + ARG_W'(prod_reg);
                    prod_reg <= gkg_pkg::PROD_W'(mul_a * mul_b);
                end
                gkg_pkg::CMD_ARG_FIN: arg_reg <= arg_reg + ARG_W'(prod_reg);
                gkg_pkg::CMD_POW_UPD: begin
                    r_reg <= round_q30;
                    n_reg <= n_reg - gkg_pkg::ARG_INT_W'(1);
                end
                gkg_pkg::CMD_VOX_STORE: begin
                    total_reg <= tot_sum[gkg_pkg::TOTAL_W] ? gkg_pkg::TOTAL_MAX
                                                           : tot_sum[gkg_pkg::TOTAL_W-1:0];
                    // x fastest, then y, then z
                    if (last_x) begin
                        vx_reg <= '0;
                        if (last_y) begin
                            vy_reg <= '0;
                            vz_reg <= vz_reg + IDX_W'(1);
                        end else begin
                            vy_reg <= vy_reg + IDX_W'(1);
                        end
                    end else begin
                        vx_reg <= vx_reg + IDX_W'(1);
                    end
                    if (last_voxel) begin
                        built_reg <= 1'b1;
                    end
                end
                gkg_pkg::CMD_RD_LOAD: begin
                    v_reg   <= ram_rdata;
                    dvd_reg <= (DVD_W'(ram_rdata) << 24) + DVD_W'(total_reg >> 1);
                    dsr_reg <= total_reg;
                    rem_reg <= '0;
                    cnt_reg <= CNT_W'(DVD_W);
                end
                default: ;
            endcase
        end
    end

    // kernel store
    assign ram_we = cmd == gkg_pkg::CMD_VOX_STORE;
    assign ram_re = cmd == gkg_pkg::CMD_RD_ISSUE;
    assign waddr  = addr_of(int'(vz_reg), int'(vy_reg), int'(vx_reg));
    assign raddr  = addr_of(int'(zp_reg), int'(yp_reg), int'(xp_reg));

    gkg_ram #(
        .WIDTH(VAL_W),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (v_new),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd == gkg_pkg::CMD_OUT_LOAD) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd == gkg_pkg::CMD_OUT_LOAD) begin
            total_out_reg <= total_reg;
            if (!rd_ok) begin
                coef_out_reg <= '0;
            end else if (total_reg == '0) begin
                coef_out_reg <= gkg_pkg::OUTC_W'(v_reg) << (24 - VALUE_FRAC_BITS);
            end else begin
                coef_out_reg <= dvd_reg[gkg_pkg::OUTC_W-1:0];
            end
            if (!func_reg) begin
                status_out_reg <= gkg_pkg::ST_OK;
            end else if (!built_reg) begin
                status_out_reg <= gkg_pkg::ST_NOT_BUILT;
            end else if (!in_range) begin
                status_out_reg <= gkg_pkg::ST_RANGE;
            end else begin
                status_out_reg <= gkg_pkg::ST_OK;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_coefficient = coef_out_reg;
    assign m_total       = total_out_reg;
    assign m_status      = status_out_reg;

    // status to the controller
    assign st.item_func  = func_reg;
    assign st.built      = built_reg;
    assign st.in_range   = in_range;
    assign st.div_done   = cnt_reg == '0;
    assign st.k_last     = int'(k_reg) == gkg_pkg::SER_TERMS;
    assign st.n_zero     = n_reg == '0;
    assign st.n_one      = n_reg == gkg_pkg::ARG_INT_W'(1);
    assign st.arg_big    = arg_reg[ARG_W-1:gkg_pkg::ARG_FRAC + gkg_pkg::ARG_INT_W] != '0;
    assign st.last_voxel = last_voxel;
    assign st.out_free   = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

[hw/rtl/gaussian_kernel_generator_3d.sv]
// Normalized 3D Gaussian kernel generator, top level.
// Read: one divide of DVD_W bits (DVD_W is the larger of VALUE_FRAC_BITS + 25 and 31, 41 by
// default) in the one-bit-per-cycle divider. Build: per voxel a Taylor series of 30 divides and
// n power multiplies, plus one exp(-1) series at the start; the shared divider dominates the build.
// One item at a time; a new request is taken while the last result waits.
// Synchronous active-low reset clears control, totals and config; the kernel store is not cleared.
`default_nettype none

module gaussian_kernel_generator_3d #(
    parameter int MAX_EXTENT      = gkg_pkg::MAX_EXTENT_DEF,
    parameter int VALUE_FRAC_BITS = gkg_pkg::VALUE_FRAC_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [gkg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gkg_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_func,
    input  wire logic [gkg_pkg::POS_W-1:0]      s_x_pos,
    input  wire logic [gkg_pkg::POS_W-1:0]      s_y_pos,
    input  wire logic [gkg_pkg::POS_W-1:0]      s_z_pos,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [gkg_pkg::OUTC_W-1:0]          m_coefficient,
    output logic [gkg_pkg::TOTAL_W-1:0]         m_total,
    output logic [gkg_pkg::STAT_W-1:0]          m_status
);

    gkg_pkg::cmd_t       cmd;
    gkg_pkg::dp_status_t st;

    gkg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    gkg_dp #(
        .MAX_EXTENT      (MAX_EXTENT),
        .VALUE_FRAC_BITS (VALUE_FRAC_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_func        (s_func),
        .s_x_pos       (s_x_pos),
        .s_y_pos       (s_y_pos),
        .s_z_pos       (s_z_pos),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coefficient (m_coefficient),
        .m_total       (m_total),
        .m_status      (m_status),
        .cmd           (cmd),
        .st            (st)
    );

endmodule

`default_nettype wire
